// ----- rtl/kdsl_pkg.sv -----
// Shared types and constants for the six-key short/long press debouncer.
package kdsl_pkg;

    localparam int NUM_KEYS       = 6;
    localparam int KEY_IDX_W      = 3;
    localparam int CODE_W         = 5;
    localparam int HOLD_W         = 8;

    typedef logic [NUM_KEYS-1:0]  key_levels_t;
    typedef logic [KEY_IDX_W-1:0] key_idx_t;
    typedef logic [CODE_W-1:0]    key_code_t;
    typedef logic [HOLD_W-1:0]    hold_t;

    localparam hold_t     THRESHOLD_RESET = 8'd120;
    localparam key_code_t LONG_CODE_BASE  = 5'd10;
    localparam key_code_t CODE_NONE       = 5'd0;

    typedef enum logic [5:0] {
        ST_IDLE        = 6'b000001,
        ST_CONFIRM     = 6'b000010,
        ST_PRESSED     = 6'b000100,
        ST_TIMING      = 6'b001000,
        ST_WAIT_CHANGE = 6'b010000,
        ST_WAIT_STABLE = 6'b100000
    } phase_t;

endpackage

// ----- rtl/kdsl_if.sv -----
// Valid/ready stream interfaces for key level beats and key code beats.
interface kdsl_key_if;
    logic                 valid;
    logic                 ready;
    kdsl_pkg::key_levels_t key_levels;

    modport source (output valid, output key_levels, input ready);
    modport sink   (input valid, input key_levels, output ready);
endinterface

interface kdsl_code_if;
    logic               valid;
    logic               ready;
    kdsl_pkg::key_code_t key_code;

    modport source (output valid, output key_code, input ready);
    modport sink   (input valid, input key_code, output ready);
endinterface

// ----- rtl/key_debounce_short_long_press.sv -----
// Six-key debouncer: one key level beat per scan tick in, one key code beat out.
// Each accepted beat of raw active-low key levels yields exactly one key_code beat:
// 0 for no event, 1..6 for a short press, 11..16 for a long press of that key.
// The key index, phase machine and hold counter are updated in the accept cycle
// and the code lands in an output register, so a beat can be taken every clock;
// key_in.ready drops only while a code waits unread.
// The long press fires once the hold count in the timing phase exceeds the
// threshold written on cfg_wr_en/cfg_wr_data (reset 120; 255 disables long press).
module key_debounce_short_long_press
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [7:0]           cfg_wr_data,
    kdsl_key_if.sink             key_in,
    kdsl_code_if.source          code_out
);
    import kdsl_pkg::*;

    phase_t    phase_reg, phase_next;
    key_idx_t  prev_key_reg;
    hold_t     hold_reg, hold_next;
    hold_t     threshold_reg;
    key_code_t code_reg, code_next;
    logic      out_valid_reg;

    key_idx_t  now_key;
    logic      same;
    logic      accept;
    key_code_t short_code;
    key_code_t long_code;

    assign key_in.ready     = !out_valid_reg || code_out.ready;
    assign accept           = key_in.valid && key_in.ready;
    assign code_out.valid   = out_valid_reg;
    assign code_out.key_code = code_reg;

    always_comb
    begin
        now_key = '0;
        for (int i = NUM_KEYS - 1; i >= 0; i--)
        begin
            if (!key_in.key_levels[i])
            begin
                now_key = KEY_IDX_W'(i + 1);
            end
        end
    end

    assign same       = (now_key == prev_key_reg);
    assign short_code = {2'b00, prev_key_reg};
    assign long_code  = (prev_key_reg == '0) ? CODE_NONE
                                             : LONG_CODE_BASE + {2'b00, prev_key_reg};

    always_comb
    begin
        phase_next = phase_reg;
        hold_next  = hold_reg;
        code_next  = CODE_NONE;
        unique case (phase_reg)
            ST_IDLE:
            begin
                if (!same)
                begin
                    phase_next = ST_CONFIRM;
                end
            end
            ST_CONFIRM:
            begin
                phase_next = same ? ST_PRESSED : ST_IDLE;
            end
            ST_PRESSED:
            begin
                if (same)
                begin
                    phase_next = ST_TIMING;
                end
                else
                begin
                    phase_next = ST_IDLE;
                    code_next  = short_code;
                end
            end
            ST_TIMING:
            begin
                if (same)
                begin
                    if (hold_reg > threshold_reg)
                    begin
                        hold_next  = '0;
                        phase_next = ST_WAIT_CHANGE;
                        code_next  = long_code;
                    end
                    else
                    begin
                        hold_next = hold_reg + 8'd1;
                    end
                end
                else
                begin
                    hold_next  = '0;
                    phase_next = ST_IDLE;
                    code_next  = short_code;
                end
            end
            ST_WAIT_CHANGE:
            begin
                if (!same)
                begin
                    phase_next = ST_WAIT_STABLE;
                end
            end
            ST_WAIT_STABLE:
            begin
                if (same)
                begin
                    phase_next = ST_IDLE;
                end
            end
            default:
            begin
                phase_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= ST_IDLE;
            prev_key_reg  <= '0;
            hold_reg      <= '0;
            threshold_reg <= THRESHOLD_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                threshold_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                phase_reg    <= phase_next;
                prev_key_reg <= now_key;
                hold_reg     <= hold_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (code_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            code_reg <= code_next;
        end
    end

endmodule

// ----- rtl/kdsl_checker.sv -----
// Port-level checks for the key debouncer, bound to the top level.
module kdsl_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [4:0] key_code
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(key_code))
        else $error("code beat dropped or changed while stalled");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (key_code <= 5'd6) || (key_code >= 5'd11 && key_code <= 5'd16))
        else $error("key code out of range");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted beat produced no code");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output register");

endmodule

bind key_debounce_short_long_press kdsl_checker u_kdsl_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (key_in.valid),
    .in_ready  (key_in.ready),
    .out_valid (code_out.valid),
    .out_ready (code_out.ready),
    .key_code  (code_out.key_code)
);

// ----- test/testbench.sv -----
// Testbench for the six-key debouncer: directed table, then random press sequences.
module testbench;
    import kdsl_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int N_DIRECTED  = 25;

    typedef struct packed {
        logic      wr_cfg;
        logic [7:0] value;
        logic      typed;
        key_code_t code;
    } stim_row_t;

    // value is the key levels, or the threshold on a config row
    localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{1'b0, 8'h3F, 1'b1, CODE_NONE},
        '{1'b0, 8'h3E, 1'b0, CODE_NONE},
        '{1'b0, 8'h3E, 1'b0, CODE_NONE},
        '{1'b0, 8'h3F, 1'b1, 5'd1},
        '{1'b0, 8'h00, 1'b0, CODE_NONE},
        '{1'b0, 8'h3F, 1'b1, CODE_NONE},
        '{1'b0, 8'h1F, 1'b0, CODE_NONE},
        '{1'b0, 8'h1F, 1'b0, CODE_NONE},
        '{1'b0, 8'h1F, 1'b0, CODE_NONE},
        '{1'b0, 8'h1F, 1'b0, CODE_NONE},
        '{1'b0, 8'h3F, 1'b1, 5'd6},
        '{1'b1, 8'd0,  1'b0, CODE_NONE},
        '{1'b0, 8'h3B, 1'b0, CODE_NONE},
        '{1'b0, 8'h3B, 1'b0, CODE_NONE},
        '{1'b0, 8'h3B, 1'b0, CODE_NONE},
        '{1'b0, 8'h3B, 1'b0, CODE_NONE},
        '{1'b0, 8'h3B, 1'b1, 5'd13},
        '{1'b0, 8'h3B, 1'b0, CODE_NONE},
        '{1'b0, 8'h3F, 1'b0, CODE_NONE},
        '{1'b0, 8'h3B, 1'b0, CODE_NONE},
        '{1'b0, 8'h3B, 1'b0, CODE_NONE},
        '{1'b0, 8'h3F, 1'b0, CODE_NONE},
        '{1'b0, 8'h3F, 1'b0, CODE_NONE},
        '{1'b0, 8'h27, 1'b0, CODE_NONE},
        '{1'b0, 8'h3D, 1'b0, CODE_NONE}
    };

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;

    kdsl_key_if  key_in ();
    kdsl_code_if code_out ();

    key_debounce_short_long_press u_top
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .key_in      (key_in),
        .code_out    (code_out)
    );

    phase_t    dbc_phase;
    key_idx_t  last_key;
    hold_t     hold_cnt;
    hold_t     long_thr;
    key_code_t code_queue [$];

    int err_count;
    int cycle_count;
    int items_sent;
    bit idle_on;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic key_idx_t lowest_pressed(input key_levels_t lv);
        for (int i = 0; i < NUM_KEYS; i++)
        begin
            if (!lv[i])
                return key_idx_t'(i + 1);
        end
        return '0;
    endfunction

    function automatic key_code_t debounce_step(input key_levels_t lv);
        key_idx_t  now_key;
        key_code_t code;
        logic      same;
        now_key = lowest_pressed(lv);
        code    = CODE_NONE;
        same    = (now_key == last_key);
        case (dbc_phase)
            ST_IDLE:
            begin
                if (!same)
                    dbc_phase = ST_CONFIRM;
            end
            ST_CONFIRM:
            begin
                dbc_phase = same ? ST_PRESSED : ST_IDLE;
            end
            ST_PRESSED:
            begin
                if (same)
                    dbc_phase = ST_TIMING;
                else
                begin
                    dbc_phase = ST_IDLE;
                    code      = key_code_t'(last_key);
                end
            end
            ST_TIMING:
            begin
                if (same)
                begin
                    if (hold_cnt > long_thr)
                    begin
                        hold_cnt  = '0;
                        dbc_phase = ST_WAIT_CHANGE;
                        code      = (last_key == '0) ? CODE_NONE
                                                     : LONG_CODE_BASE + key_code_t'(last_key);
                    end
                    else
                        hold_cnt = hold_cnt + 8'd1;
                end
                else
                begin
                    hold_cnt  = '0;
                    dbc_phase = ST_IDLE;
                    code      = key_code_t'(last_key);
                end
            end
            ST_WAIT_CHANGE:
            begin
                if (!same)
                    dbc_phase = ST_WAIT_STABLE;
            end
            ST_WAIT_STABLE:
            begin
                if (same)
                    dbc_phase = ST_IDLE;
            end
            default:
            begin
                dbc_phase = ST_IDLE;
            end
        endcase
        last_key = now_key;
        return code;
    endfunction

    function void report_mismatch(input string what);
        err_count++;
        if (err_count <= 10)
            $display("%0t: %s", $time, what);
    endfunction

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && code_out.valid && code_out.ready)
        begin
            if (code_queue.size() == 0)
                report_mismatch($sformatf("unexpected code beat %0d", code_out.key_code));
            else
            begin
                if (code_out.key_code !== code_queue[0])
                    report_mismatch($sformatf("key_code expected %0d got %0d",
                                              code_queue[0], code_out.key_code));
                void'(code_queue.pop_front());
            end
        end
    end

    // sink stalls
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 4) == 0)
            begin
                code_out.ready <= 1'b0;
                repeat ($urandom_range(0, 5)) @(negedge clk);
            end
            else
                code_out.ready <= 1'b1;
        end
    end

    // entered and left at a falling edge
    task automatic send_levels(input key_levels_t lv, input bit typed, input key_code_t typed_code);
        key_code_t code;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            key_in.valid      <= 1'b0;
            key_in.key_levels <= key_levels_t'($urandom);
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        key_in.valid      <= 1'b1;
        key_in.key_levels <= lv;
        @(posedge clk);
        while (!key_in.ready)
            @(posedge clk);
        code = debounce_step(lv);
        code_queue.push_back(typed ? typed_code : code);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic write_threshold(input logic [7:0] thr);
        key_in.valid <= 1'b0;
        while (code_queue.size() != 0)
            @(negedge clk);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= thr;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        long_thr = thr;
    endtask

    task automatic press_sequence(input bit force_long);
        int          k;
        int          sel;
        int          hold_len;
        key_levels_t lv;
        sel = force_long ? 6 : $urandom_range(0, 9);
        k   = $urandom_range(1, NUM_KEYS);
        if (sel <= 7)
        begin
            if (sel <= 3)
                hold_len = $urandom_range(1, 4);
            else if (sel <= 5)
                hold_len = $urandom_range(4, 12);
            else if (force_long || long_thr <= 30)
                hold_len = long_thr + $urandom_range(force_long ? 6 : 0, 12);
            else
                hold_len = $urandom_range(5, 15);
            repeat (hold_len)
            begin
                lv = key_levels_t'($urandom) | key_levels_t'((1 << (k - 1)) - 1);
                lv[k - 1] = 1'b0;
                send_levels(lv, 1'b0, CODE_NONE);
            end
            repeat ($urandom_range(1, 4))
                send_levels('1, 1'b0, CODE_NONE);
        end
        else if (sel == 8)
        begin
            repeat ($urandom_range(1, 4))
                send_levels(key_levels_t'($urandom), 1'b0, CODE_NONE);
        end
        else
        begin
            // one-tick glitch, then random levels, then release
            lv = '1;
            lv[k - 1] = 1'b0;
            send_levels(lv, 1'b0, CODE_NONE);
            send_levels(key_levels_t'($urandom), 1'b0, CODE_NONE);
            send_levels('1, 1'b0, CODE_NONE);
        end
    endtask

    task automatic run_phase(input logic [7:0] thr, input int budget, input bit allow_idle);
        int  target;
        bit  first;
        write_threshold(thr);
        target = items_sent + budget;
        first  = 1'b1;
        while (items_sent < target)
        begin
            idle_on = allow_idle && ($urandom_range(0, 3) != 0);
            press_sequence(first && thr > 30);
            first = 1'b0;
        end
    endtask

    initial
    begin
        rst_n             = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_wr_data       = '0;
        key_in.valid      = 1'b0;
        key_in.key_levels = '1;
        code_out.ready    = 1'b0;
        dbc_phase         = ST_IDLE;
        last_key          = '0;
        hold_cnt          = '0;
        long_thr          = THRESHOLD_RESET;
        err_count         = 0;
        cycle_count       = 0;
        items_sent        = 0;
        idle_on           = 1'b1;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (DIRECTED_ROWS[i])
        begin
            if (DIRECTED_ROWS[i].wr_cfg)
                write_threshold(DIRECTED_ROWS[i].value);
            else
                send_levels(key_levels_t'(DIRECTED_ROWS[i].value), DIRECTED_ROWS[i].typed,
                            DIRECTED_ROWS[i].code);
        end

        run_phase(8'd0, 150, 1'b1);
        run_phase(8'd5, 200, 1'b1);
        run_phase(8'd254, 350, 1'b1);
        run_phase(8'd255, 300, 1'b1);
        run_phase(8'($urandom_range(1, 20)), 200, 1'b1);
        run_phase(THRESHOLD_RESET, 200, 1'b1);
        run_phase(8'($urandom_range(0, 12)), 150, 1'b0);

        key_in.valid <= 1'b0;
        idle_on = 1'b0;
        while (code_queue.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/kdsl_pkg.sv
rtl/kdsl_if.sv
rtl/key_debounce_short_long_press.sv
rtl/kdsl_checker.sv
test/testbench.sv
